// File: design/lbpe_pkg.sv
// Shared types, constants and codes for the LED blink pattern engine.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lbpe_pkg;

    localparam int LED_COUNT    = 32;
    localparam int FIELD_W      = 32;
    localparam int PERIOD_W     = 16;
    localparam int ACTION_W     = 3;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 72;

    localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST  = 16'd70;
    localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST  = 16'd20;
    localparam logic [PERIOD_W-1:0] BEAT_ZERO_RST    = 16'd10;
    localparam logic [PERIOD_W-1:0] BEAT_ONE_RST     = 16'd20;
    localparam logic [PERIOD_W-1:0] BEAT_TWO_RST     = 16'd10;
    localparam logic [PERIOD_W-1:0] BEAT_THREE_RST   = 16'd120;
    localparam logic [FIELD_W-1:0]  POLARITY_RST     = 32'hFFFF_FFFF;
    localparam logic [FIELD_W-1:0]  PRESENT_RST      = 32'hFFFF_FFFF;

    localparam logic FUNC_TICK = 1'b0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_OFF    = 3'd0,
        ACT_ON     = 3'd1,
        ACT_TOGGLE = 3'd2,
        ACT_SLOW   = 3'd3,
        ACT_FAST   = 3'd4,
        ACT_BEAT   = 3'd5
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SLOW_PERIOD = 3'd0,
        CFG_FAST_PERIOD = 3'd1,
        CFG_BEAT_ZERO   = 3'd2,
        CFG_BEAT_ONE    = 3'd3,
        CFG_BEAT_TWO    = 3'd4,
        CFG_BEAT_THREE  = 3'd5,
        CFG_POLARITY    = 3'd6,
        CFG_PRESENT     = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        BEAT_OFF_A = 2'd0,
        BEAT_ON_A  = 2'd1,
        BEAT_OFF_B = 2'd2,
        BEAT_ON_B  = 2'd3
    } beat_phase_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] slow_period;
        logic [PERIOD_W-1:0] fast_period;
        logic [PERIOD_W-1:0] beat_zero;
        logic [PERIOD_W-1:0] beat_one;
        logic [PERIOD_W-1:0] beat_two;
        logic [PERIOD_W-1:0] beat_three;
    } timing_cfg_t;

    typedef struct packed {
        logic slow;
        logic fast;
        logic beat;
        logic beat_on;
    } tick_events_t;

endpackage

`default_nettype wire

// File: design/lbpe_timebase.sv
// Slow, fast and heartbeat counters with the heartbeat phase sequencer.
// Produces the events of the next tick; depends on lbpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbpe_timebase
    import lbpe_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire timing_cfg_t  timing,
    output tick_events_t      events
);

    logic [PERIOD_W-1:0] slow_count_reg;
    logic [PERIOD_W-1:0] slow_count_next;
    logic [PERIOD_W-1:0] fast_count_reg;
    logic [PERIOD_W-1:0] fast_count_next;
    logic [PERIOD_W-1:0] beat_count_reg;
    logic [PERIOD_W-1:0] beat_count_next;
    beat_phase_t         phase_reg;
    beat_phase_t         phase_next;

    logic [PERIOD_W:0]   slow_inc;
    logic [PERIOD_W:0]   fast_inc;
    logic [PERIOD_W:0]   beat_inc;
    logic [PERIOD_W-1:0] phase_len;
    beat_phase_t         phase_adv;

    // Phase length and the phase that follows the current one.
    always_comb
    begin
        case (phase_reg)
            BEAT_OFF_A:
            begin
                phase_len = timing.beat_zero;
                phase_adv = BEAT_ON_A;
            end
            BEAT_ON_A:
            begin
                phase_len = timing.beat_one;
                phase_adv = BEAT_OFF_B;
            end
            BEAT_OFF_B:
            begin
                phase_len = timing.beat_two;
                phase_adv = BEAT_ON_B;
            end
            BEAT_ON_B:
            begin
                phase_len = timing.beat_three;
                phase_adv = BEAT_OFF_A;
            end
            default:
            begin
                phase_len = timing.beat_zero;
                phase_adv = BEAT_ON_A;
            end
        endcase
    end

    always_comb
    begin
        slow_inc = {1'b0, slow_count_reg} + {{PERIOD_W{1'b0}}, 1'b1};
        fast_inc = {1'b0, fast_count_reg} + {{PERIOD_W{1'b0}}, 1'b1};
        beat_inc = {1'b0, beat_count_reg} + {{PERIOD_W{1'b0}}, 1'b1};

        events.slow    = slow_inc >= {1'b0, timing.slow_period};
        events.fast    = fast_inc >= {1'b0, timing.fast_period};
        events.beat    = beat_inc >= {1'b0, phase_len};
        events.beat_on = (phase_adv == BEAT_ON_A) || (phase_adv == BEAT_ON_B);

        slow_count_next = events.slow ? '0 : slow_inc[PERIOD_W-1:0];
        fast_count_next = events.fast ? '0 : fast_inc[PERIOD_W-1:0];
        beat_count_next = events.beat ? '0 : beat_inc[PERIOD_W-1:0];
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (events.beat)
        begin
            phase_next = phase_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_count_reg <= '0;
            fast_count_reg <= '0;
            beat_count_reg <= '0;
            phase_reg      <= BEAT_OFF_A;
        end
        else if (step)
        begin
            slow_count_reg <= slow_count_next;
            fast_count_reg <= fast_count_next;
            beat_count_reg <= beat_count_next;
            phase_reg      <= phase_next;
        end
    end

endmodule

`default_nettype wire

// File: design/lbpe_mask_update.sv
// Per-LED mode masks and lit state, updated by ticks and set commands.
// Depends on lbpe_pkg and on the events from lbpe_timebase.
`timescale 1ns / 1ps
`default_nettype none

module lbpe_mask_update
    import lbpe_pkg::*;
#(
    parameter int NUM_LEDS = LED_COUNT
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic                is_tick,
    input  wire logic [NUM_LEDS-1:0] mask,
    input  wire logic [ACTION_W-1:0] action,
    input  wire tick_events_t        events,
    output logic [NUM_LEDS-1:0]      lit_next,
    output logic                     bad
);

    logic [NUM_LEDS-1:0] slow_set_reg;
    logic [NUM_LEDS-1:0] slow_set_next;
    logic [NUM_LEDS-1:0] fast_set_reg;
    logic [NUM_LEDS-1:0] fast_set_next;
    logic [NUM_LEDS-1:0] beat_set_reg;
    logic [NUM_LEDS-1:0] beat_set_next;
    logic [NUM_LEDS-1:0] lit_reg;
    logic [NUM_LEDS-1:0] toggled;

    always_comb
    begin
        slow_set_next = slow_set_reg;
        fast_set_next = fast_set_reg;
        beat_set_next = beat_set_reg;
        lit_next      = lit_reg;
        bad           = 1'b0;
        toggled       = lit_reg;

        if (is_tick)
        begin
            if (events.slow)
            begin
                toggled = toggled ^ slow_set_reg;
            end
            if (events.fast)
            begin
                toggled = toggled ^ fast_set_reg;
            end
            lit_next = toggled;
            if (events.beat)
            begin
                lit_next = events.beat_on ? (toggled | beat_set_reg)
                                          : (toggled & ~beat_set_reg);
            end
        end
        else
        begin
            // A valid action first takes the LEDs out of every blink mode.
            slow_set_next = slow_set_reg & ~mask;
            fast_set_next = fast_set_reg & ~mask;
            beat_set_next = beat_set_reg & ~mask;
            case (action)
                ACT_OFF:    lit_next = lit_reg & ~mask;
                ACT_ON:     lit_next = lit_reg | mask;
                ACT_TOGGLE: lit_next = lit_reg ^ mask;
                ACT_SLOW:   slow_set_next = slow_set_next | mask;
                ACT_FAST:   fast_set_next = fast_set_next | mask;
                ACT_BEAT:   beat_set_next = beat_set_next | mask;
                default:
                begin
                    slow_set_next = slow_set_reg;
                    fast_set_next = fast_set_reg;
                    beat_set_next = beat_set_reg;
                    bad           = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_set_reg <= '0;
            fast_set_reg <= '0;
            beat_set_reg <= '0;
            lit_reg      <= '0;
        end
        else if (step)
        begin
            slow_set_reg <= slow_set_next;
            fast_set_reg <= fast_set_next;
            beat_set_reg <= beat_set_next;
            lit_reg      <= lit_next;
        end
    end

endmodule

`default_nettype wire

// File: design/led_blink_pattern_engine_core.sv
// LED blink pattern engine, top level: configuration registers, input and
// result registers around the counter and mask logic.
// Depends on lbpe_pkg, lbpe_timebase and lbpe_mask_update.
//
// Usage: each input word is a tick (tuser = 0) or a set command (tuser = 1)
// carrying an LED mask and an action. Every word yields exactly one result
// word with the lit status of all LEDs, the pin levels after polarity and
// presence, and a flag for an invalid action. The configuration port writes
// one of eight registers per cycle with cfg_we high; write it only while no
// word is in flight.
// An accepted input word is first held in the input register, then moves
// into the result register and sits there until it is taken. Throughput is
// one word per cycle while the receiver takes the results, set by the state
// update that is done combinationally between the two registers. When the
// receiver stalls, the result register holds and the input register still
// takes one more word; after that s_axis_tready drops until the result is
// taken. Reset clears all counters, modes and lit bits, empties both
// registers and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module led_blink_pattern_engine_core
    import lbpe_pkg::*;
#(
    parameter int NUM_LEDS = LED_COUNT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [31:0] led_mask, [34:32] action, [39:35] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  wire logic [0:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [31:0] status_word, [63:32] pin_levels, [64] bad_action, [71:65] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    timing_cfg_t          timing_reg;
    logic [FIELD_W-1:0]   polarity_reg;
    logic [FIELD_W-1:0]   present_reg;

    logic                 in_valid_reg;
    logic                 in_func_reg;
    logic [NUM_LEDS-1:0]  in_mask_reg;
    logic [ACTION_W-1:0]  in_action_reg;
    logic                 in_move;

    logic                 out_valid_reg;
    logic [NUM_LEDS-1:0]  out_status_reg;
    logic [NUM_LEDS-1:0]  out_pins_reg;
    logic                 out_bad_reg;

    tick_events_t         events;
    logic                 is_tick;
    logic [NUM_LEDS-1:0]  lit_next;
    logic                 bad;
    logic [NUM_LEDS-1:0]  pins_next;
    logic [FIELD_W-1:0]   status_wide;
    logic [FIELD_W-1:0]   pins_wide;

    assign in_move       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || in_move;
    assign is_tick       = (in_func_reg == FUNC_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.slow_period <= SLOW_PERIOD_RST;
            timing_reg.fast_period <= FAST_PERIOD_RST;
            timing_reg.beat_zero   <= BEAT_ZERO_RST;
            timing_reg.beat_one    <= BEAT_ONE_RST;
            timing_reg.beat_two    <= BEAT_TWO_RST;
            timing_reg.beat_three  <= BEAT_THREE_RST;
            polarity_reg           <= POLARITY_RST;
            present_reg            <= PRESENT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SLOW_PERIOD: timing_reg.slow_period <= cfg_data[PERIOD_W-1:0];
                CFG_FAST_PERIOD: timing_reg.fast_period <= cfg_data[PERIOD_W-1:0];
                CFG_BEAT_ZERO:   timing_reg.beat_zero   <= cfg_data[PERIOD_W-1:0];
                CFG_BEAT_ONE:    timing_reg.beat_one    <= cfg_data[PERIOD_W-1:0];
                CFG_BEAT_TWO:    timing_reg.beat_two    <= cfg_data[PERIOD_W-1:0];
                CFG_BEAT_THREE:  timing_reg.beat_three  <= cfg_data[PERIOD_W-1:0];
                CFG_POLARITY:    polarity_reg           <= cfg_data;
                CFG_PRESENT:     present_reg            <= cfg_data;
                default:         polarity_reg           <= polarity_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_func_reg   <= s_axis_tuser[0];
            in_mask_reg   <= s_axis_tdata[NUM_LEDS-1:0];
            in_action_reg <= s_axis_tdata[FIELD_W+ACTION_W-1:FIELD_W];
        end
    end

    lbpe_timebase u_timebase
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (in_move && is_tick),
        .timing (timing_reg),
        .events (events)
    );

    lbpe_mask_update #(
        .NUM_LEDS (NUM_LEDS)
    ) u_mask_update
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (in_move),
        .is_tick  (is_tick),
        .mask     (in_mask_reg),
        .action   (in_action_reg),
        .events   (events),
        .lit_next (lit_next),
        .bad      (bad)
    );

    assign pins_next = ~(lit_next ^ polarity_reg[NUM_LEDS-1:0]) & present_reg[NUM_LEDS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_move)
        begin
            out_status_reg <= lit_next;
            out_pins_reg   <= pins_next;
            out_bad_reg    <= bad;
        end
    end

    always_comb
    begin
        status_wide                 = '0;
        pins_wide                   = '0;
        status_wide[NUM_LEDS-1:0]   = out_status_reg;
        pins_wide[NUM_LEDS-1:0]     = out_pins_reg;
        m_axis_tdata                = '0;
        m_axis_tdata[FIELD_W-1:0]   = status_wide;
        m_axis_tdata[2*FIELD_W-1:FIELD_W] = pins_wide;
        m_axis_tdata[2*FIELD_W]     = out_bad_reg;
    end

    assign m_axis_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// File: design/lbpe_checker.sv
// Port-level checks for the LED blink pattern engine, bound to the top level.
// Depends on lbpe_pkg and led_blink_pattern_engine_core.
`timescale 1ns / 1ps
`default_nettype none

module lbpe_checker
    import lbpe_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // No result word is shown right after reset.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A new result word rises only after an input word was taken and passed through the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result word without a matching input word");

    // A rejected command leaves the lit status of the previous word unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) ##1 (m_axis_tvalid && m_axis_tdata[2*FIELD_W])
        |-> m_axis_tdata[FIELD_W-1:0] == $past(m_axis_tdata[FIELD_W-1:0]))
        else $error("invalid action changed the lit status");

endmodule

bind led_blink_pattern_engine_core lbpe_checker u_lbpe_checker (.*);

`default_nettype wire
